>>> src/cie_xy_to_srgb8_assert.svh
// Assertion macros for the chromaticity to sRGB converter.
// Included by files that check their own sequencing; no other dependencies.
`ifndef CIE_XY_TO_SRGB8_ASSERT_SVH
`define CIE_XY_TO_SRGB8_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CXS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CXS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cxs_pkg.sv
// Package for the chromaticity to sRGB converter: fixed-point constants,
// sequencer state type and the elaboration-time log2 / exp2 table builders.
package cxs_pkg;

  localparam int FRAC_BITS         = 20;
  localparam int MAX_PASSES        = 10;
  localparam int GAMMA_TABLE_DEPTH = 1024;
  localparam int IDX_BITS          = $clog2(GAMMA_TABLE_DEPTH);
  localparam int ADDR_BITS         = IDX_BITS + 1;
  localparam int W                 = 48;   // signed datapath width
  localparam int N_BITS            = $clog2(W);
  localparam int TAB_W             = FRAC_BITS + 2;
  localparam int MA                = 40;   // multiplier port A magnitude
  localparam int MB                = 24;   // multiplier port B magnitude
  localparam int P_BITS            = MA + MB;
  localparam int DIV_BITS          = 42;
  localparam int DEN_BITS          = 32;
  localparam int DCNT_BITS         = $clog2(DIV_BITS + 1);
  localparam int PASS_BITS         = $clog2(MAX_PASSES + 1);
  localparam int CW                = FRAC_BITS + 1;
  localparam int EI_MAX            = 20;
  localparam int LOG_SH            = 30 - IDX_BITS;
  localparam int EXP_SH            = FRAC_BITS - IDX_BITS;
  localparam int YMIN_I            = ((1 << FRAC_BITS) >> 16) < 1 ? 1 :
                                     ((1 << FRAC_BITS) >> 16);
  localparam logic [W-1:0] ONE_Q   = W'(1) << FRAC_BITS;
  localparam logic [63:0]  Q30     = 64'd1 << 30;

  typedef logic [TAB_W-1:0] tab_t [0:GAMMA_TABLE_DEPTH];

  typedef enum logic [5:0] {
    ST_IDLE, ST_FAC, ST_XM, ST_ZM, ST_M0, ST_M1, ST_M2, ST_SUM,
    ST_CMP, ST_SLOPE, ST_NORM, ST_LOG0, ST_LOG1, ST_LOG2, ST_LOG3,
    ST_EXP0, ST_EXP1, ST_EXP2, ST_EXP3, ST_EXP4, ST_EXP5, ST_EXP6, ST_EXP7, ST_EXP8,
    ST_NEXT, ST_PASS, ST_LUM, ST_OUT0, ST_OUT1, ST_OUT2, ST_OUT3
  } state_t;

  // Round a decimal scaled by 1e7 to the fixed-point grid
  function automatic logic signed [W-1:0] dec_q(input longint n1e7);
    logic [63:0] m;
    logic [63:0] r;
    begin
      m = (n1e7 < 0) ? 64'(-n1e7) : 64'(n1e7);
      r = ((m << FRAC_BITS) + 64'd5000000) / 64'd10000000;
      dec_q = (n1e7 < 0) ? -W'(r) : W'(r);
    end
  endfunction

  localparam logic signed [W-1:0] MAT_Q [0:8] = '{
    dec_q(32404542), dec_q(-15371385), dec_q(-4985314),
    dec_q(-9692660), dec_q(18760108),  dec_q(415560),
    dec_q(556434),   dec_q(-2040259),  dec_q(10572252)};
  localparam logic signed [W-1:0] THR_Q   = dec_q(31308);
  localparam logic signed [W-1:0] SLOPE_Q = dec_q(129200000);
  localparam logic signed [W-1:0] MULC_Q  = dec_q(10550000);
  localparam logic signed [W-1:0] OFFS_Q  = dec_q(550000);
  localparam logic signed [W-1:0] GEXP_Q  = dec_q(4200000);

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bv;
    begin
      v = v_in;
      res = '0;
      bv = 64'd1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
        if (v >= res + bv) begin
          v = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      isqrt64 = res;
    end
  endfunction

  function automatic logic [TAB_W-1:0] q30_to_q(input logic [63:0] v);
    q30_to_q = TAB_W'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  endfunction

  // log2(1 + i/D) by repeated squaring
  function automatic tab_t build_log_tab();
    tab_t t;
    logic [63:0] x;
    logic [63:0] y;
    int i;
    int k;
    begin
      for (i = 0; i < GAMMA_TABLE_DEPTH; i++) begin
        x = Q30 + ((64'(i) << 30) / GAMMA_TABLE_DEPTH);
        y = '0;
        for (k = 1; k <= 30; k++) begin
          x = (x * x + (Q30 >> 1)) >> 30;
          if (x >= 2 * Q30) begin
            x = x >> 1;
            y = y | (64'd1 << (30 - k));
          end
        end
        t[i] = q30_to_q(y);
      end
      t[GAMMA_TABLE_DEPTH] = TAB_W'(64'd1 << FRAC_BITS);
      build_log_tab = t;
    end
  endfunction

  // 2^(i/D) as a product of repeated square roots of two
  function automatic tab_t build_exp_tab();
    tab_t t;
    logic [63:0] sq [0:30];
    logic [63:0] f;
    logic [63:0] p;
    int i;
    int k;
    begin
      sq[0] = 2 * Q30;
      for (k = 1; k <= 30; k++) sq[k] = isqrt64(sq[k-1] << 30);
      for (i = 0; i < GAMMA_TABLE_DEPTH; i++) begin
        f = (64'(i) << 30) / GAMMA_TABLE_DEPTH;
        p = Q30;
        for (k = 1; k <= 30; k++)
          if (f[30-k]) p = (p * sq[k] + (Q30 >> 1)) >> 30;
        t[i] = q30_to_q(p);
      end
      t[GAMMA_TABLE_DEPTH] = TAB_W'(64'd2 << FRAC_BITS);
      build_exp_tab = t;
    end
  endfunction

endpackage

>>> src/cie_xy_to_srgb8.sv
// CIE 1931 (x, y) chromaticity to gamma-encoded 8-bit sRGB, D65 white point.
// The 16-bit inputs are scaled to Q.20 with a shift, adds and one compare, and the
// first division (luminance over y) starts at the accepting edge; the first pass
// begins once it is done. A pass computes the XYZ products, then per channel the
// matrix products and either a zero or linear channel or the power law (a
// bit-per-cycle leading-one search, then lookups and products), and ends with the
// overshoot test. Each rescale adds two divisions. An item takes 1 to 11 passes.
// in_tready is high only while the sequencer is idle; a finished word waits in the
// output register while the next word may be taken. The log2 and exp2 tables are
// registered ROMs.
`include "cie_xy_to_srgb8_assert.svh"

module cie_xy_to_srgb8
  import cxs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] x_chroma, [31:16] y_chroma
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red, [15:8] green, [23:16] blue
);

  localparam tab_t LOG_TAB = build_log_tab();
  localparam tab_t EXP_TAB = build_exp_tab();

  // round(code * 2^20 / 65535): code*2^20 = 16*code*65535 + 16*code, and the
  // remainder term is folded once more through 65536 = 65535 + 1
  function automatic logic [CW-1:0] chroma_q(input logic [15:0] code);
    logic [20:0] m;
    logic [16:0] hl;
    begin
      m  = {1'b0, code, 4'b0000} + 21'd32767;
      hl = {12'b0, m[20:16]} + {1'b0, m[15:0]};
      chroma_q = CW'({1'b0, code, 4'b0000}) + CW'(m[20:16]) + CW'(hl >= 17'd65535);
    end
  endfunction

  state_t state_r, state_nxt;

  // divider
  logic [DCNT_BITS-1:0] dcnt_r;
  logic [DIV_BITS-1:0]  dnum_r;
  logic [DEN_BITS:0]    drem_r;
  logic [DEN_BITS-1:0]  dden_r;
  logic                 div_start;
  logic [DIV_BITS-1:0]  div_num;
  logic [DEN_BITS-1:0]  div_den;
  logic                 div_busy;
  logic [DEN_BITS:0]    dshift;

  // multiplier
  logic signed [W-1:0] mul_a, mul_b, abs_a, abs_b, mq, rnd;
  logic [P_BITS-1:0]   prod_r;
  logic                neg_r;

  // ROM
  logic [ADDR_BITS-1:0] rom_addr;
  logic [TAB_W-1:0]     log_q_r, exp_q_r;

  // payload
  logic [CW-1:0]        x_r, x_nxt, cy_r, cy_nxt, lum_r, lum_nxt;
  logic signed [W-1:0]  fac_r, fac_nxt, xx_r, xx_nxt, zz_r, zz_nxt, acc_r, acc_nxt;
  logic signed [W-1:0]  c_r [3];
  logic signed [W-1:0]  c_nxt [3];
  logic [1:0]           k_r, k_nxt;
  logic [PASS_BITS-1:0] pass_r, pass_nxt;
  logic                 final_r, final_nxt;
  logic [W-1:0]         nrm_r, nrm_nxt;
  logic [N_BITS-1:0]    n_r, n_nxt;
  logic [TAB_W-1:0]     t0_r, t0_nxt;
  logic signed [W-1:0]  l_r, l_nxt, e_r, e_nxt, p_r, p_nxt;
  logic [7:0]           red_r, red_nxt, green_r, green_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [23:0]          out_data_r, out_data_nxt;

  // helpers
  logic [3:0]           mat_base;
  logic [ADDR_BITS-1:0] log_idx, exp_idx;
  logic signed [W-1:0]  mx, ei_s, rsh_full, pw, clamp_c;
  logic [4:0]           lsh, rsh;
  logic [CW-1:0]        x_in, y_in, yq;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign div_busy   = (dcnt_r != '0);

  // Shared multiplier: magnitudes in, sign kept aside, product registered
  always_comb begin
    abs_a = mul_a[W-1] ? -mul_a : mul_a;
    abs_b = mul_b[W-1] ? -mul_b : mul_b;
    rnd   = W'((prod_r + P_BITS'(ONE_Q >> 1)) >> FRAC_BITS);
    mq    = neg_r ? -rnd : rnd;
  end

  always_ff @(posedge clk) begin
    prod_r  <= P_BITS'(abs_a[MA-1:0]) * P_BITS'(abs_b[MB-1:0]);
    neg_r   <= mul_a[W-1] ^ mul_b[W-1];
    log_q_r <= LOG_TAB[rom_addr];
    exp_q_r <= EXP_TAB[rom_addr];
  end

  // Restoring divider, one quotient bit a cycle
  assign dshift = {drem_r[DEN_BITS-1:0], dnum_r[DIV_BITS-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (div_start) begin
      dcnt_r <= DCNT_BITS'(DIV_BITS);
    end else if (div_busy) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dnum_r <= div_num;
      drem_r <= '0;
      dden_r <= div_den;
    end else if (div_busy) begin
      if (dshift >= {1'b0, dden_r}) begin
        drem_r <= dshift - {1'b0, dden_r};
        dnum_r <= {dnum_r[DIV_BITS-2:0], 1'b1};
      end else begin
        drem_r <= dshift;
        dnum_r <= {dnum_r[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // Helper values from the current registers
  always_comb begin
    mat_base = {1'b0, k_r, 1'b0} + {2'b00, k_r};
    log_idx  = {1'b0, nrm_r[W-2 -: IDX_BITS]};
    exp_idx  = {1'b0, e_r[FRAC_BITS-1 -: IDX_BITS]};
    mx = (c_r[0] > c_r[1]) ? c_r[0] : c_r[1];
    if (c_r[2] > mx) mx = c_r[2];
    ei_s     = e_r >>> FRAC_BITS;
    rsh_full = -ei_s;
    lsh = (ei_s > W'(EI_MAX)) ? 5'(EI_MAX) : ei_s[4:0];
    rsh = (rsh_full > W'(31)) ? 5'd31 : rsh_full[4:0];
    if (!e_r[W-1]) pw = p_r << lsh;
    else           pw = (p_r + ((W'(1) << rsh) >> 1)) >> rsh;
    x_in = chroma_q(in_tdata[15:0]);
    y_in = chroma_q(in_tdata[31:16]);
    yq   = (y_in < CW'(YMIN_I)) ? CW'(YMIN_I) : y_in;
    clamp_c = '0;
    case (state_r)
      ST_OUT0: clamp_c = c_r[0];
      ST_OUT1: clamp_c = c_r[1];
      default: clamp_c = c_r[2];
    endcase
    if (clamp_c[W-1])             clamp_c = '0;
    else if (clamp_c > ONE_Q)     clamp_c = ONE_Q;
  end

  // Sequencer: next state, unit operands and register updates
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    rom_addr  = '0;
    x_nxt     = x_r;
    cy_nxt    = cy_r;
    lum_nxt   = lum_r;
    fac_nxt   = fac_r;
    xx_nxt    = xx_r;
    zz_nxt    = zz_r;
    acc_nxt   = acc_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    pass_nxt  = pass_r;
    final_nxt = final_r;
    nrm_nxt   = nrm_r;
    n_nxt     = n_r;
    t0_nxt    = t0_r;
    l_nxt     = l_r;
    e_nxt     = e_r;
    p_nxt     = p_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      // Take a word, scale it and start luminance over y
      ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt     = x_in;
          cy_nxt    = yq;
          lum_nxt   = CW'(ONE_Q);
          pass_nxt  = '0;
          final_nxt = 1'b0;
          div_start = 1'b1;
          div_num   = (DIV_BITS'(ONE_Q) << FRAC_BITS) + DIV_BITS'(yq >> 1);
          div_den   = DEN_BITS'(yq);
          state_nxt = ST_FAC;
        end
      end
      ST_FAC: begin
        if (!div_busy) begin
          fac_nxt   = W'(dnum_r);
          mul_a     = W'(dnum_r);
          mul_b     = W'(x_r);
          state_nxt = ST_XM;
        end
      end
      ST_XM: begin
        xx_nxt    = mq;
        mul_a     = fac_r;
        mul_b     = ONE_Q - W'(x_r) - W'(cy_r);
        state_nxt = ST_ZM;
      end
      ST_ZM: begin
        zz_nxt    = mq;
        k_nxt     = '0;
        state_nxt = ST_M0;
      end
      // Matrix row: three products summed
      ST_M0: begin
        mul_a     = xx_r;
        mul_b     = MAT_Q[mat_base];
        state_nxt = ST_M1;
      end
      ST_M1: begin
        acc_nxt   = mq;
        mul_a     = W'(lum_r);
        mul_b     = MAT_Q[mat_base + 4'd1];
        state_nxt = ST_M2;
      end
      ST_M2: begin
        acc_nxt   = acc_r + mq;
        mul_a     = zz_r;
        mul_b     = MAT_Q[mat_base + 4'd2];
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        acc_nxt   = acc_r + mq;
        state_nxt = ST_CMP;
      end
      // Companding: zero, linear segment or power law
      ST_CMP: begin
        if (acc_r[W-1] || acc_r == '0) begin
          c_nxt[k_r] = '0;
          state_nxt  = ST_NEXT;
        end else if (acc_r <= THR_Q) begin
          mul_a     = acc_r;
          mul_b     = SLOPE_Q;
          state_nxt = ST_SLOPE;
        end else begin
          nrm_nxt   = acc_r;
          n_nxt     = N_BITS'(W - 1);
          state_nxt = ST_NORM;
        end
      end
      ST_SLOPE: begin
        c_nxt[k_r] = mq;
        state_nxt  = ST_NEXT;
      end
      ST_NORM: begin
        if (nrm_r[W-1]) begin
          state_nxt = ST_LOG0;
        end else begin
          nrm_nxt = nrm_r << 1;
          n_nxt   = n_r - 1'b1;
        end
      end
      ST_LOG0: begin
        rom_addr  = log_idx;
        state_nxt = ST_LOG1;
      end
      ST_LOG1: begin
        t0_nxt    = log_q_r;
        rom_addr  = log_idx + 1'b1;
        state_nxt = ST_LOG2;
      end
      ST_LOG2: begin
        mul_a     = W'(nrm_r[W-2-IDX_BITS -: LOG_SH]);
        mul_b     = W'(log_q_r) - W'(t0_r);
        state_nxt = ST_LOG3;
      end
      ST_LOG3: begin
        l_nxt = W'(t0_r) + W'(prod_r >> LOG_SH)
              + ((W'(n_r) - W'(FRAC_BITS)) << FRAC_BITS);
        state_nxt = ST_EXP0;
      end
      ST_EXP0: begin
        mul_a     = l_r;
        mul_b     = GEXP_Q;
        state_nxt = ST_EXP1;
      end
      ST_EXP1: begin
        e_nxt     = mq;
        state_nxt = ST_EXP2;
      end
      ST_EXP2: begin
        rom_addr  = exp_idx;
        state_nxt = ST_EXP3;
      end
      ST_EXP3: begin
        t0_nxt    = exp_q_r;
        rom_addr  = exp_idx + 1'b1;
        state_nxt = ST_EXP4;
      end
      ST_EXP4: begin
        mul_a     = W'(e_r[EXP_SH-1:0]);
        mul_b     = W'(exp_q_r) - W'(t0_r);
        state_nxt = ST_EXP5;
      end
      ST_EXP5: begin
        p_nxt     = W'(t0_r) + W'(prod_r >> EXP_SH);
        state_nxt = ST_EXP6;
      end
      ST_EXP6: begin
        acc_nxt   = pw;
        state_nxt = ST_EXP7;
      end
      ST_EXP7: begin
        mul_a     = acc_r;
        mul_b     = MULC_Q;
        state_nxt = ST_EXP8;
      end
      ST_EXP8: begin
        c_nxt[k_r] = mq - OFFS_Q;
        state_nxt  = ST_NEXT;
      end
      ST_NEXT: begin
        if (k_r == 2'd2) begin
          state_nxt = ST_PASS;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_M0;
        end
      end
      // Rescale luminance while the brightest channel overshoots and passes remain
      ST_PASS: begin
        if (final_r || mx <= ONE_Q) begin
          state_nxt = ST_OUT0;
        end else begin
          div_start = 1'b1;
          div_num   = (DIV_BITS'(lum_r) << FRAC_BITS) + DIV_BITS'(mx[DEN_BITS-1:0] >> 1);
          div_den   = mx[DEN_BITS-1:0];
          pass_nxt  = pass_r + 1'b1;
          final_nxt = (pass_r + 1'b1 == PASS_BITS'(MAX_PASSES));
          state_nxt = ST_LUM;
        end
      end
      ST_LUM: begin
        if (!div_busy) begin
          lum_nxt   = dnum_r[CW-1:0];
          div_start = 1'b1;
          div_num   = (DIV_BITS'(dnum_r[CW-1:0]) << FRAC_BITS) + DIV_BITS'(cy_r >> 1);
          div_den   = DEN_BITS'(cy_r);
          state_nxt = ST_FAC;
        end
      end
      // Clamp and scale each channel to 8 bits
      ST_OUT0: begin
        mul_a     = clamp_c;
        mul_b     = W'(255);
        state_nxt = ST_OUT1;
      end
      ST_OUT1: begin
        red_nxt   = mq[7:0];
        mul_a     = clamp_c;
        mul_b     = W'(255);
        state_nxt = ST_OUT2;
      end
      ST_OUT2: begin
        green_nxt = mq[7:0];
        mul_a     = clamp_c;
        mul_b     = W'(255);
        state_nxt = ST_OUT3;
      end
      ST_OUT3: begin
        mul_a = clamp_c;
        mul_b = W'(255);
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {mq[7:0], green_r, red_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    cy_r       <= cy_nxt;
    lum_r      <= lum_nxt;
    fac_r      <= fac_nxt;
    xx_r       <= xx_nxt;
    zz_r       <= zz_nxt;
    acc_r      <= acc_nxt;
    c_r        <= c_nxt;
    k_r        <= k_nxt;
    pass_r     <= pass_nxt;
    final_r    <= final_nxt;
    nrm_r      <= nrm_nxt;
    n_r        <= n_nxt;
    t0_r       <= t0_nxt;
    l_r        <= l_nxt;
    e_r        <= e_nxt;
    p_r        <= p_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks on sequencing
  `CXS_ASSERT_NOW(a_idle_div_free, in_tready, !div_busy, "word taken while divider busy")
  `CXS_ASSERT_NEXT(a_accept_starts_div, in_tvalid && in_tready,
    dcnt_r == DCNT_BITS'(DIV_BITS) && state_r == ST_FAC, "divider not started on accept")
  `CXS_ASSERT_NOW(a_pass_bound, state_r == ST_PASS && !final_r,
    pass_r < PASS_BITS'(MAX_PASSES), "pass count beyond limit")
  `CXS_ASSERT_NOW(a_norm_nonzero, state_r == ST_NORM, nrm_r != '0,
    "normalising a zero value")

endmodule
